// ===== hw/rtl/base64_stream_decoder_assert.svh =====
// assertion macros for the base64 stream decoder checker
// expects signals clk and rst_n in the scope where a macro is used
`ifndef BASE64_STREAM_DECODER_ASSERT_SVH
`define BASE64_STREAM_DECODER_ASSERT_SVH

// same-cycle implication, disabled in reset
`define B64D_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled in reset
`define B64D_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/b64d_pkg.sv =====
// shared types, constants and the character classifier of the base64 decoder
// no dependencies
package b64d_pkg;

  localparam logic [7:0] PAD_CHAR   = 8'h3D;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5A;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_Z = 8'h7A;
  localparam logic [7:0] CH_DIGIT_0 = 8'h30;
  localparam logic [7:0] CH_DIGIT_9 = 8'h39;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_SLASH   = 8'h2F;
  localparam logic [5:0] SX_LOWER_BASE = 6'd26;
  localparam logic [5:0] SX_DIGIT_BASE = 6'd52;
  localparam logic [5:0] SX_PLUS       = 6'd62;
  localparam logic [5:0] SX_SLASH      = 6'd63;

  localparam logic [15:0] CAP_RESET = 16'hFFFF;
  localparam int          CFG_AW    = 2;
  localparam logic [0:0]  REG_OUT_CAPACITY = 1'b0;

  // classified character handed from front to back
  typedef struct packed {
    logic [5:0] sextet;
    logic       is_pad;
    logic       invalid;
    logic       last_char;
  } cls_item_t;

  // queue status seen by the front and back
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  function automatic cls_item_t classify(input logic [7:0] ch, input logic last_char);
    cls_item_t  r;
    logic [7:0] d;
    r = '0;
    d = '0;
    r.last_char = last_char;
    r.is_pad    = (ch == PAD_CHAR);
    if (ch >= CH_UPPER_A && ch <= CH_UPPER_Z) begin
      d = ch - CH_UPPER_A;
      r.sextet = d[5:0];
    end else if (ch >= CH_LOWER_A && ch <= CH_LOWER_Z) begin
      d = ch - CH_LOWER_A;
      r.sextet = d[5:0] + SX_LOWER_BASE;
    end else if (ch >= CH_DIGIT_0 && ch <= CH_DIGIT_9) begin
      d = ch - CH_DIGIT_0;
      r.sextet = d[5:0] + SX_DIGIT_BASE;
    end else if (ch == CH_PLUS) begin
      r.sextet = SX_PLUS;
    end else if (ch == CH_SLASH) begin
      r.sextet = SX_SLASH;
    end else begin
      r.invalid = 1'b1;
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/b64d_in_if.sv =====
// character channel: valid/ready with one base64 character and a last flag
// no dependencies
interface b64d_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       last_char;

  modport source (output valid, output ch, output last_char, input ready);
  modport sink   (input valid, input ch, input last_char, output ready);
endinterface

// ===== hw/rtl/b64d_out_if.sv =====
// result channel: valid/ready with a decoded byte or the closing status
// no dependencies
interface b64d_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  data_byte;
  logic        is_final;
  logic        rejected;
  logic [15:0] byte_count;

  modport source (output valid, output data_byte, output is_final, output rejected,
                  output byte_count, input ready);
  modport sink   (input valid, input data_byte, input is_final, input rejected,
                  input byte_count, output ready);
endinterface

// ===== hw/rtl/b64d_front.sv =====
// front part: takes character transfers and classifies them against the alphabet
// depends on b64d_pkg and b64d_in_if
module b64d_front import b64d_pkg::*; (
  b64d_in_if.sink   in_if,
  input  q_status_t q_status,
  output logic      push,
  output cls_item_t push_item
);

  assign in_if.ready = !q_status.full;
  assign push        = in_if.valid && !q_status.full;
  assign push_item   = classify(in_if.ch, in_if.last_char);

endmodule

// ===== hw/rtl/b64d_queue.sv =====
// two-entry queue of classified characters between front and back
// depends on b64d_pkg
module b64d_queue import b64d_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  cls_item_t push_item,
  input  logic      pop,
  output cls_item_t head,
  output q_status_t status
);

  cls_item_t  slot_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;

  assign status.full  = (count_r == 2'd2);
  assign status.empty = (count_r == 2'd0);
  assign head         = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + 1'b1;
    rd_ptr_nxt = rd_ptr_r + 1'b1;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_nxt;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_nxt;
      end
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// ===== hw/rtl/b64d_back.sv =====
// back part: quad tracking, byte assembly, capacity limit and closing status
// depends on b64d_pkg and b64d_out_if
module b64d_back import b64d_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [15:0] out_capacity,
  input  cls_item_t   head,
  input  q_status_t   q_status,
  output logic        pop,
  b64d_out_if.source  out_if
);

  typedef enum logic [1:0] {
    PH_DATA   = 2'b01,
    PH_STATUS = 2'b10
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [1:0]  qpos_r, qpos_nxt, qpos_n;
  logic [5:0]  prev_r, prev_nxt, prev_n;
  logic        err_r, err_nxt, err_n;
  logic [15:0] bytes_r, bytes_nxt, bytes_n;

  logic        oval_r, oval_nxt;
  logic [7:0]  obyte_r, obyte_nxt;
  logic        ofinal_r, ofinal_nxt;
  logic        orej_r, orej_nxt;
  logic [15:0] ocount_r, ocount_nxt;

  logic        slot_free;
  logic        have_byte;
  logic        emit_byte;
  logic [7:0]  byte_val;

  assign out_if.valid      = oval_r;
  assign out_if.data_byte  = obyte_r;
  assign out_if.is_final   = ofinal_r;
  assign out_if.rejected   = orej_r;
  assign out_if.byte_count = ocount_r;

  assign slot_free = !oval_r || out_if.ready;

  // one character step on the current string state
  always_comb begin
    qpos_n    = qpos_r;
    prev_n    = prev_r;
    err_n     = err_r;
    have_byte = 1'b0;
    byte_val  = '0;
    if (!err_r) begin
      if (head.is_pad && qpos_r[1]) begin
        prev_n = '0;
        qpos_n = qpos_r + 2'd1;
      end else if (head.invalid) begin
        err_n = 1'b1;
      end else begin
        unique case (qpos_r)
          2'd1:    byte_val = {prev_r, head.sextet[5:4]};
          2'd2:    byte_val = {prev_r[3:0], head.sextet[5:2]};
          2'd3:    byte_val = {prev_r[1:0], head.sextet};
          default: byte_val = '0;
        endcase
        have_byte = (qpos_r != 2'd0);
        prev_n    = head.sextet;
        qpos_n    = qpos_r + 2'd1;
      end
    end
    emit_byte = have_byte && (bytes_r < out_capacity);
    bytes_n   = emit_byte ? bytes_r + 16'd1 : bytes_r;
  end

  // sequencing of queue pops and result loads
  always_comb begin
    phase_nxt  = phase_r;
    qpos_nxt   = qpos_r;
    prev_nxt   = prev_r;
    err_nxt    = err_r;
    bytes_nxt  = bytes_r;
    pop        = 1'b0;
    oval_nxt   = slot_free ? 1'b0 : oval_r;
    obyte_nxt  = obyte_r;
    ofinal_nxt = ofinal_r;
    orej_nxt   = orej_r;
    ocount_nxt = ocount_r;
    if (!q_status.empty) begin
      unique case (phase_r)
        PH_DATA: begin
          if (!emit_byte && !head.last_char) begin
            qpos_nxt  = qpos_n;
            prev_nxt  = prev_n;
            err_nxt   = err_n;
            bytes_nxt = bytes_n;
            pop       = 1'b1;
          end else if (slot_free) begin
            oval_nxt = 1'b1;
            if (emit_byte) begin
              obyte_nxt  = byte_val;
              ofinal_nxt = 1'b0;
              orej_nxt   = 1'b0;
              ocount_nxt = '0;
              qpos_nxt   = qpos_n;
              prev_nxt   = prev_n;
              err_nxt    = err_n;
              bytes_nxt  = bytes_n;
              if (head.last_char) begin
                phase_nxt = PH_STATUS;
              end else begin
                pop = 1'b1;
              end
            end else begin
              // last character with no byte: status straight away
              obyte_nxt  = '0;
              ofinal_nxt = 1'b1;
              orej_nxt   = err_n || (qpos_n != 2'd0);
              ocount_nxt = bytes_n;
              qpos_nxt   = '0;
              prev_nxt   = '0;
              err_nxt    = 1'b0;
              bytes_nxt  = '0;
              pop        = 1'b1;
            end
          end
        end
        PH_STATUS: begin
          if (slot_free) begin
            oval_nxt   = 1'b1;
            obyte_nxt  = '0;
            ofinal_nxt = 1'b1;
            orej_nxt   = err_r || (qpos_r != 2'd0);
            ocount_nxt = bytes_r;
            qpos_nxt   = '0;
            prev_nxt   = '0;
            err_nxt    = 1'b0;
            bytes_nxt  = '0;
            pop        = 1'b1;
            phase_nxt  = PH_DATA;
          end
        end
        default: phase_nxt = PH_DATA;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_DATA;
      qpos_r  <= '0;
      prev_r  <= '0;
      err_r   <= 1'b0;
      bytes_r <= '0;
      oval_r  <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      qpos_r  <= qpos_nxt;
      prev_r  <= prev_nxt;
      err_r   <= err_nxt;
      bytes_r <= bytes_nxt;
      oval_r  <= oval_nxt;
    end
  end

  always_ff @(posedge clk) begin
    obyte_r  <= obyte_nxt;
    ofinal_r <= ofinal_nxt;
    orej_r   <= orej_nxt;
    ocount_r <= ocount_nxt;
  end

endmodule

// ===== hw/rtl/base64_stream_decoder.sv =====
// base64 stream decoder: one character per cycle while the output is not stalled, bytes out as soon as known
// a character transfer passes the queue and then the output register before its result shows
// throughput: one character per cycle while the output is not stalled; a last
//   character that also completes a byte gives the byte first, then the closing status
// reset: rst_n synchronous active low, clears string state, queue and output,
//   out_capacity returns to 65535
// depends on b64d_pkg, b64d_in_if, b64d_out_if, b64d_front, b64d_queue, b64d_back
module base64_stream_decoder import b64d_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  b64d_in_if.sink           in_if,
  b64d_out_if.source        out_if,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [31:0]       cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready
);

  // configuration register, only out_capacity, at byte address zero
  logic [15:0] cap_r;
  logic        cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
    end else if (cfg_wr && (cfg_paddr == CFG_AW'(4 * REG_OUT_CAPACITY))) begin
      cap_r <= cfg_pwdata[15:0];
    end
  end

  assign cfg_prdata = {16'h0000, cap_r};

  // front classifies each transfer, the queue decouples it from the back
  q_status_t q_status;
  logic      push;
  logic      pop;
  cls_item_t push_item;
  cls_item_t head;

  b64d_front u_front (
    .in_if     (in_if),
    .q_status  (q_status),
    .push      (push),
    .push_item (push_item)
  );

  b64d_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .status    (q_status)
  );

  // back walks the quad, assembles bytes and closes each string with a status
  b64d_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_capacity (cap_r),
    .head         (head),
    .q_status     (q_status),
    .pop          (pop),
    .out_if       (out_if)
  );

endmodule

// ===== hw/rtl/b64d_checker.sv =====
// port-level checks of the base64 stream decoder, attached by bind
// depends on base64_stream_decoder_assert.svh and base64_stream_decoder
`include "base64_stream_decoder_assert.svh"

module b64d_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  out_data_byte,
  input logic        out_is_final,
  input logic        out_rejected,
  input logic [15:0] out_byte_count,
  input logic        cfg_psel,
  input logic        cfg_penable,
  input logic        cfg_pwrite,
  input logic [31:0] cfg_pwdata,
  input logic [31:0] cfg_prdata
);

  `B64D_ASSERT_NOW(a_status_no_byte, out_valid && out_is_final, out_data_byte == 8'h00, "status carries a data byte")
  `B64D_ASSERT_NOW(a_data_clean, out_valid && !out_is_final, !out_rejected && out_byte_count == 16'h0000, "data transfer carries status fields")
  `B64D_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data_byte) && $stable(out_is_final) && $stable(out_byte_count), "stalled result changed")
  `B64D_ASSERT_NEXT(a_cfg_readback, cfg_psel && cfg_penable && cfg_pwrite, cfg_prdata[15:0] == $past(cfg_pwdata[15:0]) && cfg_prdata[31:16] == 16'h0000, "capacity readback mismatch")

endmodule

bind base64_stream_decoder b64d_checker u_b64d_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_if.valid),
  .out_ready      (out_if.ready),
  .out_data_byte  (out_if.data_byte),
  .out_is_final   (out_if.is_final),
  .out_rejected   (out_if.rejected),
  .out_byte_count (out_if.byte_count),
  .cfg_psel       (cfg_psel),
  .cfg_penable    (cfg_penable),
  .cfg_pwrite     (cfg_pwrite),
  .cfg_pwdata     (cfg_pwdata),
  .cfg_prdata     (cfg_prdata)
);

// ===== tb/sv/testbench.sv =====
// self-checking testbench for the base64 stream decoder: directed strings, then
// random strings under several idle/stall mixes and capacity settings
// depends on b64d_pkg, b64d_in_if, b64d_out_if and base64_stream_decoder
module testbench;
  import b64d_pkg::*;

  localparam int                TIME_LIMIT  = 2_000_000;
  localparam int                PHASE_CHARS = 200;
  localparam int                REPORT_MAX  = 40;
  localparam logic [CFG_AW-1:0] CAP_ADDR    = CFG_AW'(4 * REG_OUT_CAPACITY);

  // one result item as seen on the output channel
  typedef struct packed {
    logic [7:0]  data_byte;
    logic        is_final;
    logic        rejected;
    logic [15:0] byte_count;
  } dec_result_t;

  // mirrors the decoder state and holds the results still owed by the block
  class decode_mirror;
    logic [15:0] capacity;
    logic [1:0]  quad_pos;
    logic [5:0]  prev_sextet;
    logic        error_seen;
    logic [15:0] bytes_out;
    dec_result_t due_results[$];
    int          errors;
    int          reported;

    function new();
      capacity = CAP_RESET;
      errors   = 0;
      reported = 0;
      clear_string();
    endfunction

    function void clear_string();
      quad_pos    = '0;
      prev_sextet = '0;
      error_seen  = 1'b0;
      bytes_out   = '0;
    endfunction

    // six-bit value of a text character, -1 outside the alphabet
    function int sextet_of_char(logic [7:0] c);
      if (c >= CH_UPPER_A && c <= CH_UPPER_Z) return int'(c) - int'(CH_UPPER_A);
      if (c >= CH_LOWER_A && c <= CH_LOWER_Z) return int'(c) - int'(CH_LOWER_A) + 26;
      if (c >= CH_DIGIT_0 && c <= CH_DIGIT_9) return int'(c) - int'(CH_DIGIT_0) + 52;
      if (c == CH_PLUS) return 62;
      if (c == CH_SLASH) return 63;
      return -1;
    endfunction

    // one accepted character: queue the bytes and status it must produce
    function void take_char(logic [7:0] c, logic last);
      int          sx;
      logic [7:0]  value;
      logic        has_byte;
      dec_result_t r;
      value    = '0;
      has_byte = 1'b0;
      if (!error_seen) begin
        sx = sextet_of_char(c);
        if (c == PAD_CHAR && quad_pos >= 2'd2) begin
          // padding: no byte, stored value becomes zero
          prev_sextet = '0;
        end else if (sx < 0) begin
          error_seen = 1'b1;
        end else begin
          case (quad_pos)
            2'd1: begin
              value    = {prev_sextet, sx[5:4]};
              has_byte = 1'b1;
            end
            2'd2: begin
              value    = {prev_sextet[3:0], sx[5:2]};
              has_byte = 1'b1;
            end
            2'd3: begin
              value    = {prev_sextet[1:0], sx[5:0]};
              has_byte = 1'b1;
            end
            default: ;
          endcase
          prev_sextet = sx[5:0];
        end
        if (!error_seen) begin
          quad_pos = quad_pos + 2'd1;
          if (has_byte && bytes_out < capacity) begin
            r = '{data_byte: value, is_final: 1'b0, rejected: 1'b0, byte_count: 16'd0};
            due_results.push_back(r);
            bytes_out = bytes_out + 16'd1;
          end
        end
      end
      if (last) begin
        r = '{data_byte: 8'd0, is_final: 1'b1,
              rejected: error_seen || quad_pos != 2'd0, byte_count: bytes_out};
        due_results.push_back(r);
        clear_string();
      end
    endfunction

    function void flag(string what);
      errors++;
      if (reported < REPORT_MAX) begin
        reported++;
        $display("%0t: %s", $time, what);
      end
    endfunction

    // one result transfer against the oldest expectation
    function void check_result(dec_result_t got);
      dec_result_t want;
      if (due_results.size() == 0) begin
        flag($sformatf("unexpected result byte %02h final %0b rejected %0b count %0d",
                       got.data_byte, got.is_final, got.rejected, got.byte_count));
        return;
      end
      want = due_results.pop_front();
      if (got.data_byte !== want.data_byte || got.is_final !== want.is_final ||
          got.rejected !== want.rejected || got.byte_count !== want.byte_count) begin
        flag($sformatf({"mismatch expected byte %02h final %0b rejected %0b count %0d,",
                        " got byte %02h final %0b rejected %0b count %0d"},
                       want.data_byte, want.is_final, want.rejected, want.byte_count,
                       got.data_byte, got.is_final, got.rejected, got.byte_count));
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [CFG_AW-1:0] cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  b64d_in_if  in_ch();
  b64d_out_if out_ch();

  base64_stream_decoder i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_if       (in_ch),
    .out_if      (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  decode_mirror mirror;
  logic [7:0]   text[$];        // characters of the string being built
  int           send_idle_pct;  // chance per cycle that the sender holds back
  int           recv_stall_pct; // chance per cycle that the receiver stalls
  int           hold_left;      // cycles left of a forced receiver hold-off
  int           chars_sent;

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // receiver: ready changes on the falling edge, random stalls or a long hold-off
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_ch.ready = 1'b0;
        hold_left--;
      end else begin
        out_ch.ready = ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // every result transfer is checked at the rising edge where it happens
  always @(posedge clk) begin
    if (rst_n && out_ch.valid === 1'b1 && out_ch.ready) begin
      mirror.check_result('{data_byte: out_ch.data_byte, is_final: out_ch.is_final,
                            rejected: out_ch.rejected, byte_count: out_ch.byte_count});
    end
  end

  // one character transfer; called and returning at a falling edge, valid is left high
  // so that back-to-back characters keep it up without a dip
  task automatic send_char(logic [7:0] c, logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid     = 1'b1;
    in_ch.ch        = c;
    in_ch.last_char = last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    mirror.take_char(c, last);
    chars_sent++;
    @(negedge clk);
  endtask

  // send the built string with the last flag on its final character
  task automatic send_text();
    for (int i = 0; i < text.size(); i++) begin
      send_char(text[i], i == text.size() - 1);
    end
    text.delete();
  endtask

  task automatic send_ascii(string s);
    for (int i = 0; i < s.len(); i++) text.push_back(s[i]);
    send_text();
  endtask

  function automatic logic [7:0] char_of_sextet(logic [5:0] v);
    if (v < 6'd26) return CH_UPPER_A + 8'(v);
    if (v < 6'd52) return CH_LOWER_A + 8'(v - 6'd26);
    if (v < 6'd62) return CH_DIGIT_0 + 8'(v - 6'd52);
    if (v == 6'd62) return CH_PLUS;
    return CH_SLASH;
  endfunction

  // append the standard encoding of nbytes random bytes, padded to whole quads
  function automatic void encode_bytes(int nbytes);
    logic [23:0] grp;
    int          left;
    left = nbytes;
    while (left > 0) begin
      grp = 24'($urandom);
      text.push_back(char_of_sextet(grp[23:18]));
      text.push_back(char_of_sextet(grp[17:12]));
      text.push_back(left >= 2 ? char_of_sextet(grp[11:6]) : PAD_CHAR);
      text.push_back(left >= 3 ? char_of_sextet(grp[5:0]) : PAD_CHAR);
      left -= 3;
    end
  endfunction

  function automatic int random_len();
    if ($urandom_range(99) < 5) return $urandom_range(60, 30);
    return $urandom_range(12, 1);
  endfunction

  // mostly well-formed strings with random content, the rest broken or noise
  task automatic random_string();
    int kind;
    int cut;
    int idx;
    kind = $urandom_range(99);
    if (kind < 62) begin
      encode_bytes(random_len());
    end else if (kind < 72) begin
      // padding inside the string, not only at its end
      encode_bytes($urandom_range(5, 1));
      encode_bytes(random_len());
    end else if (kind < 80) begin
      // one character replaced by any code, often an invalid one
      encode_bytes(random_len());
      text[$urandom_range(text.size() - 1)] = 8'($urandom_range(255));
    end else if (kind < 87) begin
      // length not a multiple of four
      encode_bytes(random_len());
      cut = $urandom_range(3, 1);
      repeat (cut) void'(text.pop_back());
    end else if (kind < 92) begin
      // padding in the first or second place of a quad
      encode_bytes(random_len());
      idx = 4 * $urandom_range((text.size() / 4) - 1) + $urandom_range(1);
      text[idx] = PAD_CHAR;
    end else begin
      repeat ($urandom_range(8, 1)) text.push_back(8'($urandom_range(255)));
    end
    send_text();
  endtask

  // sender pauses until every owed result has arrived, plus the block's latency
  task automatic drain_results();
    in_ch.valid = 1'b0;
    while (mirror.due_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // write out_capacity over the config port, then read it back
  task automatic write_capacity(logic [15:0] cap);
    cfg_psel    = 1'b1;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b1;
    cfg_paddr   = CAP_ADDR;
    cfg_pwdata  = {16'd0, cap};
    @(negedge clk);
    cfg_penable = 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    mirror.capacity = cap;
    @(negedge clk);
    // read back: new setup cycle with psel kept high
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    @(negedge clk);
    cfg_penable = 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    if (cfg_prdata[15:0] !== cap) begin
      mirror.flag($sformatf("capacity readback expected %0d, got %0d", cap,
                            cfg_prdata[15:0]));
    end
    @(negedge clk);
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
  endtask

  // one run of random strings under a given idle/stall mix and capacity; a squeezed run
  // starts with a long receiver hold-off and pauses the sender halfway
  task automatic run_phase(int idle_pct, int stall_pct, logic [15:0] cap, bit squeeze);
    int  start;
    bit  paused;
    paused = 1'b0;
    drain_results();
    write_capacity(cap);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    start = chars_sent;
    if (squeeze) hold_left = 400;
    while (chars_sent - start < PHASE_CHARS) begin
      random_string();
      if (squeeze && !paused && chars_sent - start >= PHASE_CHARS / 2) begin
        drain_results();
        paused = 1'b1;
      end
    end
  endtask

  initial begin
    mirror          = new();
    send_idle_pct   = 0;
    recv_stall_pct  = 0;
    hold_left       = 0;
    chars_sent      = 0;
    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.ch        = '0;
    in_ch.last_char = 1'b0;
    cfg_psel        = 1'b0;
    cfg_penable     = 1'b0;
    cfg_pwrite      = 1'b0;
    cfg_paddr       = '0;
    cfg_pwdata      = '0;
    repeat (7) @(negedge clk);
    rst_n = 1'b1;

    // directed strings at reset capacity
    send_ascii("AZaz09+/");   // alphabet edges, two full quads
    send_ascii("//8=");       // all-ones bytes, padding in fourth place only
    send_ascii("AB=C");       // padding in third place followed by a data character
    send_ascii("A=Zz");       // padding in second place is invalid, rest swallowed
    send_ascii("AB");         // length not a multiple of four
    text.push_back(8'hFF);    // invalid character, highest code
    send_text();
    text.push_back(8'h00);    // invalid character, lowest code
    send_text();

    run_phase(0, 0, 16'hFFFF, 1'b0);
    run_phase(47, 0, 16'd0, 1'b0);
    run_phase(0, 47, 16'd1, 1'b0);
    run_phase(30, 30, 16'd5, 1'b0);
    run_phase(0, 0, 16'($urandom_range(24, 2)), 1'b1);
    run_phase(30, 30, 16'hFFFF, 1'b0);

    drain_results();
    repeat (10) @(posedge clk);
    if (mirror.errors == 0 && mirror.due_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // hard stop in case the block hangs
  initial begin
    #(TIME_LIMIT);
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
